FILE: hdl/efpf_pkg.sv
// Shared types and constants for the edge-flag polygon fill unit.
// Used by every module of the block; depends on nothing.
package efpf_pkg;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FILL_COLOR    = 2'd2;

  // Register reset values
  localparam logic [6:0] WIDTH_RESET  = 7'd64;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;
  localparam logic [7:0] COLOR_RESET  = 8'd1;

  // Coordinates widened by one bit so that differences of 16-bit values fit
  localparam int COORD_W = 17;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Crossing arithmetic: |dx*(2k+1)+dy| < 2^33, denominator 2*dy < 2^18
  localparam int NUM_W      = 36;
  localparam int PROD_W     = 35;
  localparam int DIVIDEND_W = 33;
  localparam int DIVISOR_W  = 18;
  localparam int QUOT_W     = 18;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // Classified command handed from front to back
  typedef struct packed {
    op_t         op;
    logic [7:0]  color;
    logic        skip;    // nothing to touch in the store
    logic        status;  // horizontal edge
    coord_t      x1;      // edge: x of the upper end
    coord_t      dx;      // edge: x2 - x1
    coord_t      dy;      // edge: y2 - y1, positive
    coord_t      k0;      // edge: first row minus y1
    coord_t      lo_x;    // fill min x, read x
    coord_t      lo_y;    // fill min y, edge first row, read y
    coord_t      hi_x;    // fill max x (exclusive)
    coord_t      hi_y;    // fill max y, edge end row (exclusive)
    coord_t      w;       // clamped active width
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_MUL,
    BK_NUM,
    BK_DIV0,
    BK_DIV1,
    BK_ROW_RD,
    BK_ROW_WR,
    BK_FILL_RD,
    BK_FILL_WR,
    BK_READ,
    BK_READ_WAIT,
    BK_CLEAR,
    BK_FINISH
  } bk_state_t;

endpackage

FILE: hdl/efpf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on efpf_pkg for operand widths.
module efpf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [efpf_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [efpf_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             done,
  output logic [efpf_pkg::DIVIDEND_W-1:0]  quotient,
  output logic [efpf_pkg::DIVISOR_W-1:0]   remainder
);

  localparam int NW = efpf_pkg::DIVIDEND_W;
  localparam int DW = efpf_pkg::DIVISOR_W;
  localparam int CW = efpf_pkg::DIV_CNT_W;

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  // One shift-subtract step
  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
    quo_nxt = {quo_r[NW-2:0], fits};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: hdl/efpf_cmdq.sv
// Two-entry command queue between the front classifier and the back sequencer.
// Depends on efpf_pkg for the command type and depth.
module efpf_cmdq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  efpf_pkg::cmd_t   push_cmd,
  output logic             full,
  input  logic             pop,
  output efpf_pkg::cmd_t   pop_cmd,
  output logic             empty
);

  localparam int AW = efpf_pkg::CMDQ_AW;

  efpf_pkg::cmd_t entry_r [efpf_pkg::CMDQ_DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    count_r;
  logic           do_push;
  logic           do_pop;

  assign full    = count_r == (AW+1)'(efpf_pkg::CMDQ_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rd_ptr_r];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (!do_push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

FILE: hdl/efpf_front.sv
// Front end: configuration registers, input handshake and command classification.
// Depends on efpf_pkg for the command type, opcodes and register indexes.
module efpf_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_x_a,
  input  logic signed [15:0] in_y_a,
  input  logic signed [15:0] in_x_b,
  input  logic signed [15:0] in_y_b,
  input  logic               hold,
  input  logic               q_full,
  output logic               q_push,
  output efpf_pkg::cmd_t     q_cmd
);

  localparam efpf_pkg::coord_t MaxW = efpf_pkg::COORD_W'(MAX_WIDTH);
  localparam efpf_pkg::coord_t MaxH = efpf_pkg::COORD_W'(MAX_HEIGHT);

  logic [6:0] width_r;
  logic [6:0] height_r;
  logic [7:0] color_r;

  efpf_pkg::coord_t w_raw, h_raw, w_s, h_s;
  efpf_pkg::coord_t xa, ya, xb, yb;
  efpf_pkg::coord_t x1, y1, x2, y2, top, bot;
  logic             swap;
  logic             hit;
  efpf_pkg::op_t    op;

  function automatic efpf_pkg::coord_t clamp_c(efpf_pkg::coord_t v, efpf_pkg::coord_t hi);
    efpf_pkg::coord_t r;
    if (v < 0)       r = '0;
    else if (v > hi) r = hi;
    else             r = v;
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= efpf_pkg::WIDTH_RESET;
      height_r <= efpf_pkg::HEIGHT_RESET;
      color_r  <= efpf_pkg::COLOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efpf_pkg::REG_ACTIVE_WIDTH:  width_r  <= cfg_data[6:0];
        efpf_pkg::REG_ACTIVE_HEIGHT: height_r <= cfg_data[6:0];
        efpf_pkg::REG_FILL_COLOR:    color_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active size clamped to 1..MAX
  always_comb begin
    w_raw = {10'd0, width_r};
    h_raw = {10'd0, height_r};
    if (width_r == 7'd0) w_s = efpf_pkg::COORD_W'(1);
    else if (w_raw > MaxW) w_s = MaxW;
    else w_s = w_raw;
    if (height_r == 7'd0) h_s = efpf_pkg::COORD_W'(1);
    else if (h_raw > MaxH) h_s = MaxH;
    else h_s = h_raw;
  end

  // Handshake
  assign in_full = q_full || hold;
  assign q_push  = in_push && !in_full;

  // Classification
  always_comb begin
    op   = efpf_pkg::op_t'(in_operation);
    xa   = {in_x_a[15], in_x_a};
    ya   = {in_y_a[15], in_y_a};
    xb   = {in_x_b[15], in_x_b};
    yb   = {in_y_b[15], in_y_b};
    swap = ya > yb;
    x1   = swap ? xb : xa;
    y1   = swap ? yb : ya;
    x2   = swap ? xa : xb;
    y2   = swap ? ya : yb;
    top  = (y1 < 0) ? '0 : y1;
    bot  = (y2 < h_s) ? y2 : h_s;
    hit  = (xa >= 0) && (ya >= 0) && (xa < w_s) && (ya < h_s);

    q_cmd        = '0;
    q_cmd.op     = op;
    q_cmd.color  = color_r;
    q_cmd.w      = w_s;
    unique case (op)
      efpf_pkg::OP_EDGE: begin
        q_cmd.status = (ya == yb);
        q_cmd.skip   = (ya == yb) || (top >= bot);
        q_cmd.x1     = x1;
        q_cmd.dx     = x2 - x1;
        q_cmd.dy     = y2 - y1;
        q_cmd.k0     = top - y1;
        q_cmd.lo_y   = top;
        q_cmd.hi_y   = bot;
      end
      efpf_pkg::OP_FILL: begin
        q_cmd.lo_x = clamp_c(xa, w_s);
        q_cmd.hi_x = clamp_c(xb, w_s);
        q_cmd.lo_y = clamp_c(ya, h_s);
        q_cmd.hi_y = clamp_c(yb, h_s);
        q_cmd.skip = (q_cmd.lo_x >= q_cmd.hi_x) || (q_cmd.lo_y >= q_cmd.hi_y);
      end
      efpf_pkg::OP_READ: begin
        q_cmd.lo_x = xa;
        q_cmd.lo_y = ya;
        q_cmd.skip = !hit;
      end
      efpf_pkg::OP_CLEAR: begin
        q_cmd.skip = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/efpf_back.sv
// Back end: sequencer that carries out commands on the frame store, with the
// crossing divider and the result register. Depends on efpf_pkg and efpf_div.
module efpf_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  efpf_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  output logic             init_busy,
  output logic             out_empty,
  input  logic             out_pop,
  output logic             out_status,
  output logic [7:0]       out_pixel_value
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int NW    = efpf_pkg::DIVIDEND_W;
  localparam int DW    = efpf_pkg::DIVISOR_W;
  localparam int QW    = efpf_pkg::QUOT_W;

  efpf_pkg::bk_state_t state_r, state_nxt;
  efpf_pkg::cmd_t      cmd_r, cmd_nxt;

  logic [YW-1:0]                         row_r, row_nxt;
  logic [XW-1:0]                         col_r, col_nxt;
  logic [AW-1:0]                         addr_r, addr_nxt;
  logic [AW-1:0]                         clr_cnt_r, clr_cnt_nxt;
  logic signed [efpf_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic                                  neg_r, neg_nxt;
  logic signed [QW-1:0]                  q_r, q_nxt, qs_r, qs_nxt;
  logic [DW-1:0]                         r_r, r_nxt, rs_r, rs_nxt;
  logic                                  inside_r, inside_nxt;
  logic                                  fin_status_r, fin_status_nxt;
  logic [7:0]                            fin_pix_r, fin_pix_nxt;
  logic                                  res_valid_r;
  logic                                  res_status_r;
  logic [7:0]                            res_pix_r;
  logic                                  res_load;

  // Frame store
  logic [PIXEL_BITS-1:0] frame_mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [PIXEL_BITS-1:0] mem_wdata;

  // Divider hookup
  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic [DW-1:0] div_rem;

  // Datapath helpers
  logic signed [efpf_pkg::NUM_W-1:0] num_c, num_mag;
  efpf_pkg::coord_t                  dx_mag, w_m1;
  logic [DW-1:0]                     den;
  logic signed [QW-1:0]              q_m, q_fix, q_step;
  logic [DW-1:0]                     r_fix, r_step;
  logic                              r_nz;
  logic [DW:0]                       r_sum;
  logic                              r_ge;
  logic signed [QW:0]                px_c;
  logic [XW-1:0]                     col_c;
  logic [PIXEL_BITS-1:0]             color_px;
  logic                              is_color;
  logic                              ins_c;
  logic                              row_last, col_last, clr_last;

  function automatic logic [AW-1:0] pix_addr(logic [YW-1:0] y, logic [XW-1:0] x);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  efpf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Crossing arithmetic: floor correction, per-row step and x clamp; also fill parity and end flags
  always_comb begin
    den      = {cmd_r.dy[DW-2:0], 1'b0};
    num_c    = efpf_pkg::NUM_W'(prod_r) + efpf_pkg::NUM_W'(cmd_r.dy);
    num_mag  = (num_c < 0) ? -num_c : num_c;
    dx_mag   = (cmd_r.dx < 0) ? -cmd_r.dx : cmd_r.dx;
    q_m      = $signed(div_quo[QW-1:0]);
    r_nz     = div_rem != '0;
    q_fix    = neg_r ? (QW'(0) - q_m - $signed({{(QW-1){1'b0}}, r_nz})) : q_m;
    r_fix    = (neg_r && r_nz) ? (den - div_rem) : div_rem;
    r_sum    = {1'b0, r_r} + {1'b0, rs_r};
    r_ge     = r_sum >= {1'b0, den};
    r_step   = r_ge ? DW'(r_sum - {1'b0, den}) : r_sum[DW-1:0];
    q_step   = q_r + qs_r + $signed({{(QW-1){1'b0}}, r_ge});
    px_c     = (QW+1)'(cmd_r.x1) + (QW+1)'(q_r);
    w_m1     = cmd_r.w - efpf_pkg::COORD_W'(1);
    if (px_c < 0)                        col_c = '0;
    else if (px_c >= (QW+1)'(cmd_r.w))   col_c = w_m1[XW-1:0];
    else                                 col_c = px_c[XW-1:0];
    color_px = PIXEL_BITS'(cmd_r.color);
    is_color = rd_data_r == color_px;
    ins_c    = inside_r ^ is_color;
    row_last = ({1'b0, row_r} + 1'b1) == cmd_r.hi_y[YW:0];
    col_last = ({1'b0, col_r} + 1'b1) == cmd_r.hi_x[XW:0];
    clr_last = clr_cnt_r == AW'(DEPTH - 1);
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= efpf_pkg::BK_INIT;
    else        state_r <= state_nxt;
  end

  // Next state and control
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    addr_nxt       = addr_r;
    clr_cnt_nxt    = clr_cnt_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    q_nxt          = q_r;
    r_nxt          = r_r;
    qs_nxt         = qs_r;
    rs_nxt         = rs_r;
    inside_nxt     = inside_r;
    fin_status_nxt = fin_status_r;
    fin_pix_nxt    = fin_pix_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    div_dividend   = '0;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = '0;
    mem_raddr      = addr_r;
    res_load       = 1'b0;
    unique case (state_r) inside
      efpf_pkg::BK_INIT, efpf_pkg::BK_CLEAR: begin
        // sweep the whole store, one pixel a cycle
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          clr_cnt_nxt = '0;
          state_nxt   = (state_r == efpf_pkg::BK_INIT) ? efpf_pkg::BK_IDLE
                                                       : efpf_pkg::BK_FINISH;
        end
      end
      efpf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          fin_status_nxt = q_cmd.status;
          fin_pix_nxt    = '0;
          row_nxt        = q_cmd.lo_y[YW-1:0];
          col_nxt        = q_cmd.lo_x[XW-1:0];
          inside_nxt     = 1'b0;
          if (q_cmd.skip) begin
            state_nxt = efpf_pkg::BK_FINISH;
          end else begin
            unique case (q_cmd.op)
              efpf_pkg::OP_EDGE:  state_nxt = efpf_pkg::BK_MUL;
              efpf_pkg::OP_FILL:  state_nxt = efpf_pkg::BK_FILL_RD;
              efpf_pkg::OP_READ:  state_nxt = efpf_pkg::BK_READ;
              efpf_pkg::OP_CLEAR: state_nxt = efpf_pkg::BK_CLEAR;
              default:            state_nxt = efpf_pkg::BK_FINISH;
            endcase
          end
        end
      end
      efpf_pkg::BK_MUL: begin
        // dx * (2*k0 + 1)
        prod_nxt  = cmd_r.dx * $signed({1'b0, cmd_r.k0[15:0], 1'b1});
        state_nxt = efpf_pkg::BK_NUM;
      end
      efpf_pkg::BK_NUM: begin
        div_start    = 1'b1;
        div_dividend = num_mag[NW-1:0];
        neg_nxt      = num_c < 0;
        state_nxt    = efpf_pkg::BK_DIV0;
      end
      efpf_pkg::BK_DIV0: begin
        if (div_done) begin
          q_nxt        = q_fix;
          r_nxt        = r_fix;
          // per-row step: floor(2*dx / 2*dy)
          div_start    = 1'b1;
          div_dividend = {{(NW-efpf_pkg::COORD_W-1){1'b0}}, dx_mag, 1'b0};
          neg_nxt      = cmd_r.dx < 0;
          state_nxt    = efpf_pkg::BK_DIV1;
        end
      end
      efpf_pkg::BK_DIV1: begin
        if (div_done) begin
          qs_nxt    = q_fix;
          rs_nxt    = r_fix;
          state_nxt = efpf_pkg::BK_ROW_RD;
        end
      end
      efpf_pkg::BK_ROW_RD: begin
        mem_raddr = pix_addr(row_r, col_c);
        addr_nxt  = mem_raddr;
        state_nxt = efpf_pkg::BK_ROW_WR;
      end
      efpf_pkg::BK_ROW_WR: begin
        // toggle between color and zero
        mem_we    = 1'b1;
        mem_wdata = (rd_data_r != color_px) ? color_px : '0;
        q_nxt     = q_step;
        r_nxt     = r_step;
        if (row_last) begin
          state_nxt = efpf_pkg::BK_FINISH;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = efpf_pkg::BK_ROW_RD;
        end
      end
      efpf_pkg::BK_FILL_RD: begin
        mem_raddr = pix_addr(row_r, col_r);
        addr_nxt  = mem_raddr;
        state_nxt = efpf_pkg::BK_FILL_WR;
      end
      efpf_pkg::BK_FILL_WR: begin
        // parity scan: flip on a flag pixel, paint while inside
        mem_we    = ins_c;
        mem_wdata = color_px;
        if (col_last) begin
          col_nxt    = cmd_r.lo_x[XW-1:0];
          inside_nxt = 1'b0;
          if (row_last) begin
            state_nxt = efpf_pkg::BK_FINISH;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = efpf_pkg::BK_FILL_RD;
          end
        end else begin
          col_nxt    = col_r + 1'b1;
          inside_nxt = ins_c;
          state_nxt  = efpf_pkg::BK_FILL_RD;
        end
      end
      efpf_pkg::BK_READ: begin
        mem_raddr = pix_addr(row_r, col_r);
        state_nxt = efpf_pkg::BK_READ_WAIT;
      end
      efpf_pkg::BK_READ_WAIT: begin
        fin_pix_nxt = 8'(rd_data_r);
        state_nxt   = efpf_pkg::BK_FINISH;
      end
      efpf_pkg::BK_FINISH: begin
        if (!res_valid_r || out_pop) begin
          res_load  = 1'b1;
          state_nxt = efpf_pkg::BK_IDLE;
        end
      end
      default: state_nxt = efpf_pkg::BK_IDLE;
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Sequencer payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    addr_r       <= addr_nxt;
    prod_r       <= prod_nxt;
    neg_r        <= neg_nxt;
    q_r          <= q_nxt;
    r_r          <= r_nxt;
    qs_r         <= qs_nxt;
    rs_r         <= rs_nxt;
    inside_r     <= inside_nxt;
    fin_status_r <= fin_status_nxt;
    fin_pix_r    <= fin_pix_nxt;
  end

  // Frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= frame_mem[mem_raddr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n)        res_valid_r <= 1'b0;
    else if (res_load) res_valid_r <= 1'b1;
    else if (out_pop)  res_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status_r <= fin_status_r;
      res_pix_r    <= fin_pix_r;
    end
  end

  assign init_busy       = state_r == efpf_pkg::BK_INIT;
  assign out_empty       = !res_valid_r;
  assign out_status      = res_status_r;
  assign out_pixel_value = res_pix_r;

endmodule

FILE: hdl/edge_flag_polygon_fill_unit.sv
// Edge-flag polygon fill unit: front classifier, command queue, back sequencer.
// Edge items run two 33-step divisions to set up the crossing, then read and write
// one pixel per row; fill reads and writes each pixel of the clamped region; read
// fetches one pixel; clear sweeps the whole store. The back takes the next item
// only once it is done with the current one, while the queue holds two more. An unpopped result stalls the back.
// Reset (synchronous, rst_n low) starts a MAX_WIDTH*MAX_HEIGHT clearing pass, in_full high.
module edge_flag_polygon_fill_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_x_a,
  input  logic signed [15:0] in_y_a,
  input  logic signed [15:0] in_x_b,
  input  logic signed [15:0] in_y_b,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_status,
  output logic [7:0]         out_pixel_value
);

  logic           init_busy;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  efpf_pkg::cmd_t push_cmd;
  efpf_pkg::cmd_t pop_cmd;

  efpf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_x_a       (in_x_a),
    .in_y_a       (in_y_a),
    .in_x_b       (in_x_b),
    .in_y_b       (in_y_b),
    .hold         (init_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  efpf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  efpf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_pixel_value (out_pixel_value)
  );

  // Reset always starts the clearing pass, which blocks input
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input not blocked after reset");

  // Back end only takes a command that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // Queue full and empty are exclusive
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_empty)
    else $error("command queue full and empty");

  // An accepted transaction is queued on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !q_empty)
    else $error("accepted transaction missing from queue");

endmodule
